[sv/mclbc_pkg.sv]
// ----------------------------------------------------------------------------
// mclbc_pkg - LED blink controller shared definitions
// Request codes, register indexes, reset values and payload/state types.
// ----------------------------------------------------------------------------
package mclbc_pkg;

	localparam int CHANNELS_DEF = 8;   // default channel count
	localparam int OUT_W        = 8;   // channels visible on the result fields
	localparam int CNT_W        = 16;  // on/off/cycle counter width
	localparam int CFG_W        = 8;   // widest configuration register
	localparam int CFG_IDX_W    = 1;   // two registers
	localparam int CH_W         = 3;   // channel field width

	// request codes; code 3 is unused and changes no state
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} req_type_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_MASK = 1'b1;

	localparam logic [CFG_W-1:0] DIV_RESET = 8'd10;
	localparam logic [CFG_W-1:0] ALM_RESET = 8'd31;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [CH_W-1:0]  channel;
		logic [CNT_W-1:0] on_ticks;
		logic [CNT_W-1:0] off_ticks;
		logic [CNT_W-1:0] cycles;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] led_pins;
		logic [OUT_W-1:0] running_mask;
	} res_t;

	// per-channel blink state
	typedef struct packed {
		logic             enabled;
		logic             stop_pending;
		logic             phase_off;
		logic             lit;
		logic [CNT_W-1:0] on_len;
		logic [CNT_W-1:0] off_len;
		logic [CNT_W-1:0] cycle_limit;
		logic [CNT_W-1:0] phase_count;
		logic [CNT_W-1:0] cycle_count;
	} chan_t;

endpackage

[sv/mclbc_if.sv]
// ----------------------------------------------------------------------------
// mclbc_if - request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mclbc_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [mclbc_pkg::CH_W-1:0]  channel;
	logic [mclbc_pkg::CNT_W-1:0] on_ticks;
	logic [mclbc_pkg::CNT_W-1:0] off_ticks;
	logic [mclbc_pkg::CNT_W-1:0] cycles;

	modport source(output valid, req_type, channel, on_ticks, off_ticks, cycles,
		input ready);
	modport sink(input valid, req_type, channel, on_ticks, off_ticks, cycles,
		output ready);
endinterface

interface mclbc_res_if;
	logic                        valid;
	logic                        ready;
	logic [mclbc_pkg::OUT_W-1:0] led_pins;
	logic [mclbc_pkg::OUT_W-1:0] running_mask;

	modport source(output valid, led_pins, running_mask, input ready);
	modport sink(input valid, led_pins, running_mask, output ready);
endinterface

[sv/multi_channel_led_blink_controller_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_led_blink_controller_unit - multi-channel LED blink controller
// Tick prescaler plus per-channel on/off/repeat blink engines, one result per item.
// ----------------------------------------------------------------------------
// Path: the accepted item is held in the input reg (stage 1), and its result
//   in the result reg (stage 2).
// Throughput: 1 item per cycle while results are taken; all channels update in
//   parallel in one pass of compare/increment logic between the two registers.
//   A stalled result holds stage 1, and with it the input.
// Reset (arst_n low, async): all channels cleared and dark, prescaler zero,
//   tick_divide = 10, active_low_mask = 31, both pipeline stages empty.
// ----------------------------------------------------------------------------
module multi_channel_led_blink_controller_unit #(
	parameter int CHANNELS = mclbc_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mclbc_req_if.sink                       req,
	mclbc_res_if.source                     res,
	input  logic                            cfg_we,
	input  logic [mclbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mclbc_pkg::CFG_W-1:0]     cfg_wdata
);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [mclbc_pkg::CFG_W-1:0] tick_divide_q;
	logic [mclbc_pkg::OUT_W-1:0] alm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= mclbc_pkg::DIV_RESET;
			alm_q         <= mclbc_pkg::ALM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mclbc_pkg::CFG_TICK_DIVIDE:     tick_divide_q <= cfg_wdata;
				mclbc_pkg::CFG_ACTIVE_LOW_MASK: alm_q         <= cfg_wdata;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Handshake: stage 1 holds the accepted item, stage 2 the result.
	// Stage 1 is processed whenever the result register is free or being
	// emptied this cycle. A stalled result keeps stage 1 full, so the input
	// backs up only while both stages hold an item.
	// ---------------------------------------------------------------------
	mclbc_pkg::req_t req_s1;
	logic            vld_s1;
	mclbc_pkg::res_t res_s2;
	logic            vld_s2;
	logic            req_acc;
	logic            proc;

	assign proc      = vld_s1 && (!vld_s2 || res.ready);
	assign req.ready = !vld_s1 || proc;
	assign req_acc   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_acc) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1.req_type  <= req.req_type;
			req_s1.channel   <= req.channel;
			req_s1.on_ticks  <= req.on_ticks;
			req_s1.off_ticks <= req.off_ticks;
			req_s1.cycles    <= req.cycles;
		end
	end

	// ---------------------------------------------------------------------
	// Channel state and prescaler
	// ---------------------------------------------------------------------
	mclbc_pkg::chan_t            chan_q   [CHANNELS];
	mclbc_pkg::chan_t            chan_nxt [CHANNELS];
	logic [mclbc_pkg::CFG_W-1:0] prescale_q;
	logic [mclbc_pkg::CFG_W-1:0] prescale_nxt;
	logic [mclbc_pkg::CFG_W-1:0] pre_inc;
	logic                        fire;

	// One processed tick for one channel. A pending stop wipes the channel
	// and skips the advance. Steady-on (off_len 0) and disabled channels hold.
	function automatic mclbc_pkg::chan_t advance(mclbc_pkg::chan_t ch);
		mclbc_pkg::chan_t              r;
		logic [mclbc_pkg::CNT_W-1:0]   pc;
		logic [mclbc_pkg::CNT_W-1:0]   cc;
		r  = ch;
		pc = ch.phase_count + 16'd1;
		cc = ch.cycle_count + 16'd1;
		if (ch.stop_pending) begin
			r = '0;
		end else if (ch.enabled && ch.off_len != '0) begin
			r.phase_count = pc;
			if (!ch.phase_off) begin
				// lit phase over: go dark
				if (pc >= ch.on_len) begin
					r.lit         = 1'b0;
					r.phase_count = '0;
					r.phase_off   = 1'b1;
				end
			end else if (pc >= ch.off_len) begin
				// end of one period
				if (ch.cycle_limit != '0 && cc >= ch.cycle_limit) begin
					// last period: stay dark, counts left as they stand
					r.cycle_count = cc;
					r.enabled     = 1'b0;
					r.off_len     = '0;
				end else begin
					if (ch.cycle_limit != '0) begin
						r.cycle_count = cc;
					end
					r.phase_count = '0;
					r.phase_off   = 1'b0;
					r.lit         = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		pre_inc      = prescale_q + 8'd1;
		fire         = 1'b0;
		prescale_nxt = prescale_q;
		for (int c = 0; c < CHANNELS; c++) begin
			chan_nxt[c] = chan_q[c];
		end
		unique case (req_s1.req_type)
			mclbc_pkg::REQ_TICK: begin
				// tick_divide of 0 fires on every tick
				fire         = pre_inc >= tick_divide_q;
				prescale_nxt = fire ? '0 : pre_inc;
			end
			mclbc_pkg::REQ_START: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(req_s1.channel) == c && req_s1.on_ticks != '0) begin
						chan_nxt[c].on_len       = req_s1.on_ticks;
						chan_nxt[c].off_len      = req_s1.off_ticks;
						chan_nxt[c].cycle_limit  = req_s1.cycles;
						chan_nxt[c].phase_count  = '0;
						chan_nxt[c].cycle_count  = '0;
						chan_nxt[c].phase_off    = 1'b0;
						chan_nxt[c].stop_pending = 1'b0;
						chan_nxt[c].enabled      = 1'b1;
						chan_nxt[c].lit          = 1'b1;
					end
				end
			end
			mclbc_pkg::REQ_STOP: begin
				// dark at once; the clear waits for the next processed tick
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(req_s1.channel) == c) begin
						chan_nxt[c].enabled      = 1'b0;
						chan_nxt[c].stop_pending = 1'b1;
						chan_nxt[c].lit          = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (fire) begin
			for (int c = 0; c < CHANNELS; c++) begin
				chan_nxt[c] = advance(chan_q[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				chan_q[c] <= '0;
			end
		end else if (proc) begin
			prescale_q <= prescale_nxt;
			for (int c = 0; c < CHANNELS; c++) begin
				chan_q[c] <= chan_nxt[c];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result: state after the item. Only the low eight channels are shown;
	// bits of absent channels read zero on both fields.
	// ---------------------------------------------------------------------
	logic [mclbc_pkg::OUT_W-1:0] pin_vec;
	logic [mclbc_pkg::OUT_W-1:0] run_vec;

	for (genvar b = 0; b < mclbc_pkg::OUT_W; b++) begin : g_out
		if (b < CHANNELS) begin : g_has
			assign pin_vec[b] = chan_nxt[b].lit ^ alm_q[b];
			assign run_vec[b] = chan_nxt[b].enabled;
		end else begin : g_none
			assign pin_vec[b] = 1'b0;
			assign run_vec[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (proc) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_s2.led_pins     <= pin_vec;
			res_s2.running_mask <= run_vec;
		end
	end

	assign res.valid        = vld_s2;
	assign res.led_pins     = res_s2.led_pins;
	assign res.running_mask = res_s2.running_mask;

endmodule

[sv/mclbc_checker.sv]
// ----------------------------------------------------------------------------
// mclbc_checker - port-level checks for the LED blink controller
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
module mclbc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mclbc_pkg::OUT_W-1:0] led_pins,
	input logic [mclbc_pkg::OUT_W-1:0] running_mask
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(led_pins) && $stable(running_mask))
		else $error("result changed while stalled");

	// input only backs up when the result side is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with result side free");

	// a fresh result follows an accepted item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("result without an item");

endmodule

bind multi_channel_led_blink_controller_unit mclbc_checker u_mclbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.led_pins     (res.led_pins),
	.running_mask (res.running_mask)
);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - multi_channel_led_blink_controller_unit self-checking bench
// A directed table (reset values, extremes, ignored starts, stop then tick,
// steady-on, cycle end), then random blink traffic under several divider
// and polarity settings. Every accepted item is run through a local model
// of the blink engines. Each result is checked against the model or the typed levels.
// ----------------------------------------------------------------------------
module testbench;

	// request code 3 is unused by the block; it must still return a result
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int         NCH        = mclbc_pkg::CHANNELS_DEF;
	localparam int         SETTLE     = 6;     // quiet cycles after the owed results are back
	localparam int         DRAIN_MAX  = 20000; // cycles allowed for the final drain
	localparam int         MAX_PRINTS = 30;

	typedef struct {
		mclbc_pkg::req_t item;
		bit              known;   // expected levels typed into the table
		mclbc_pkg::res_t levels;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic                            cfg_we;
	logic [mclbc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mclbc_pkg::CFG_W-1:0]     cfg_wdata;

	mclbc_req_if req_ch();
	mclbc_res_if res_ch();

	multi_channel_led_blink_controller_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Local model of the blink engines
	// ------------------------------------------------------------------
	logic [mclbc_pkg::CFG_W-1:0] tick_div;      // mirrors tick_divide
	logic [mclbc_pkg::CFG_W-1:0] polarity;      // mirrors active_low_mask
	logic [7:0]                  prescaler;
	mclbc_pkg::chan_t            blink [NCH];

	mclbc_pkg::res_t pending_levels[$];    // pin/running levels still owed by the block
	stim_row_t       table_rows[$];
	int              err_count;
	int              burst_left;

	// one processed tick for one channel
	function automatic void step_blinker(input int c);
		if (blink[c].stop_pending) begin
			// stop taken: channel wiped, no advance on this tick
			blink[c] = '0;
			return;
		end
		if (!blink[c].enabled || blink[c].off_len == '0)
			return;
		blink[c].phase_count = blink[c].phase_count + 16'd1;
		if (!blink[c].phase_off) begin
			if (blink[c].phase_count >= blink[c].on_len) begin
				blink[c].lit         = 1'b0;
				blink[c].phase_count = '0;
				blink[c].phase_off   = 1'b1;
			end
		end else if (blink[c].phase_count >= blink[c].off_len) begin
			// dark phase over: one period done
			if (blink[c].cycle_limit != '0) begin
				blink[c].cycle_count = blink[c].cycle_count + 16'd1;
				if (blink[c].cycle_count >= blink[c].cycle_limit) begin
					// last period: parks dark, counts left as they are
					blink[c].enabled = 1'b0;
					blink[c].off_len = '0;
					return;
				end
			end
			blink[c].phase_count = '0;
			blink[c].phase_off   = 1'b0;
			blink[c].lit         = 1'b1;
		end
	endfunction

	// apply one item to the model, return the levels seen after it
	function automatic mclbc_pkg::res_t predict_levels(input mclbc_pkg::req_t it);
		mclbc_pkg::res_t r;
		int              ch;
		ch = it.channel;
		case (it.req_type)
			mclbc_pkg::REQ_TICK: begin
				prescaler = prescaler + 8'd1;
				if (prescaler >= tick_div) begin
					prescaler = '0;
					for (int c = 0; c < NCH; c++)
						step_blinker(c);
				end
			end
			mclbc_pkg::REQ_START: begin
				// on time of zero: start ignored
				if (it.on_ticks != '0) begin
					blink[ch].on_len       = it.on_ticks;
					blink[ch].off_len      = it.off_ticks;
					blink[ch].cycle_limit  = it.cycles;
					blink[ch].phase_count  = '0;
					blink[ch].cycle_count  = '0;
					blink[ch].phase_off    = 1'b0;
					blink[ch].stop_pending = 1'b0;
					blink[ch].enabled      = 1'b1;
					blink[ch].lit          = 1'b1;
				end
			end
			mclbc_pkg::REQ_STOP: begin
				// dark right away; state cleared on the next processed tick
				blink[ch].enabled      = 1'b0;
				blink[ch].stop_pending = 1'b1;
				blink[ch].lit          = 1'b0;
			end
			default: ;
		endcase
		for (int c = 0; c < mclbc_pkg::OUT_W; c++) begin
			r.led_pins[c]     = blink[c].lit ^ polarity[c];
			r.running_mask[c] = blink[c].enabled;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Clock and timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** multi_channel_led_blink_controller_unit: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: ready stalls on a pattern that is chosen anew at random
	// (no stall, random, periodic, heavy random)
	// ------------------------------------------------------------------
	initial begin
		int unsigned rx_cycle;
		int unsigned rx_mode;
		res_ch.ready = 1'b0;
		rx_cycle = 0;
		rx_mode  = 0;
		forever begin
			@(negedge clk);
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       res_ch.ready = 1'b1;
				1:       res_ch.ready = ($urandom_range(0, 3) != 0);
				2:       res_ch.ready = (rx_cycle % 8 < 5);
				default: res_ch.ready = ($urandom_range(0, 1) == 1);
			endcase
			rx_cycle++;
		end
	end

	// result checker: oldest expectation against each accepted result
	always @(posedge clk) begin
		mclbc_pkg::res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_levels.size() == 0) begin
				err_count++;
				if (err_count <= MAX_PRINTS)
					$display("%0t: unexpected result pins=%h running=%h", $time,
						res_ch.led_pins, res_ch.running_mask);
			end else begin
				want = pending_levels.pop_front();
				if (res_ch.led_pins !== want.led_pins) begin
					err_count++;
					if (err_count <= MAX_PRINTS)
						$display("%0t: led_pins expected %h actual %h", $time,
							want.led_pins, res_ch.led_pins);
				end
				if (res_ch.running_mask !== want.running_mask) begin
					err_count++;
					if (err_count <= MAX_PRINTS)
						$display("%0t: running_mask expected %h actual %h", $time,
							want.running_mask, res_ch.running_mask);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// send one item inside the current burst; a burst ends with a random gap
	task automatic put_item(input mclbc_pkg::req_t it, input bit known,
		input mclbc_pkg::res_t typed);
		int              gap;
		mclbc_pkg::res_t model_out;
		if (burst_left == 0) begin
			// about a third of bursts follow the last with no gap at all
			gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
			end
			burst_left = int'($urandom_range(1, 24));
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid     = 1'b1;
		req_ch.req_type  = it.req_type;
		req_ch.channel   = it.channel;
		req_ch.on_ticks  = it.on_ticks;
		req_ch.off_ticks = it.off_ticks;
		req_ch.cycles    = it.cycles;
		do
			@(posedge clk);
		while (!req_ch.ready);
		model_out = predict_levels(it);
		pending_levels.push_back(known ? typed : model_out);
	endtask

	// hold off new items until every owed result is back
	task automatic wait_for_levels();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write; block is idle whenever this is called
	task automatic write_reg(input logic [mclbc_pkg::CFG_IDX_W-1:0] idx,
		input logic [mclbc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		if (idx == mclbc_pkg::CFG_TICK_DIVIDE)
			tick_div = val;
		else
			polarity = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic add_row(input logic [1:0] kind, input int ch, input logic [15:0] on_t,
		input logic [15:0] off_t, input logic [15:0] cyc, input bit known,
		input logic [7:0] pins, input logic [7:0] run);
		stim_row_t row;
		row.item.req_type          = kind;
		row.item.channel           = ch[mclbc_pkg::CH_W-1:0];
		row.item.on_ticks          = on_t;
		row.item.off_ticks         = off_t;
		row.item.cycles            = cyc;
		row.known                  = known;
		row.levels.led_pins        = pins;
		row.levels.running_mask    = run;
		table_rows.push_back(row);
	endtask

	// random blink traffic under one divider/polarity setting;
	// pause_at >= 0 makes the sender stop there until all results are back
	task automatic run_phase(input logic [7:0] div, input logic [7:0] pol, input int n_items,
		input int pause_at);
		mclbc_pkg::req_t it;
		int              roll;
		wait_for_levels();
		write_reg(mclbc_pkg::CFG_TICK_DIVIDE, div);
		write_reg(mclbc_pkg::CFG_ACTIVE_LOW_MASK, pol);
		for (int i = 0; i < n_items; i++) begin
			if (i == pause_at)
				wait_for_levels();
			// payload bits are random even where the block ignores them
			it.channel   = 3'($urandom_range(0, NCH - 1));
			it.on_ticks  = 16'($urandom);
			it.off_ticks = 16'($urandom);
			it.cycles    = 16'($urandom);
			roll = int'($urandom_range(0, 99));
			if (roll < 60) begin
				it.req_type = mclbc_pkg::REQ_TICK;
			end else if (roll < 85) begin
				// mostly short periods so blinks and cycle ends happen often
				it.req_type = mclbc_pkg::REQ_START;
				if ($urandom_range(0, 7) != 0)
					it.on_ticks = 16'($urandom_range(1, 4));
				if ($urandom_range(0, 15) == 0)
					it.on_ticks = '0;
				if ($urandom_range(0, 7) != 0)
					it.off_ticks = 16'($urandom_range(0, 4));
				if ($urandom_range(0, 7) != 0)
					it.cycles = 16'($urandom_range(0, 3));
			end else if (roll < 95) begin
				it.req_type = mclbc_pkg::REQ_STOP;
			end else begin
				it.req_type = REQ_UNUSED;
			end
			put_item(it, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int waited;
		err_count        = 0;
		burst_left       = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = mclbc_pkg::CFG_TICK_DIVIDE;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = mclbc_pkg::REQ_TICK;
		req_ch.channel   = '0;
		req_ch.on_ticks  = '0;
		req_ch.off_ticks = '0;
		req_ch.cycles    = '0;

		// model starts from the reset values
		tick_div  = mclbc_pkg::DIV_RESET;
		polarity  = mclbc_pkg::ALM_RESET;
		prescaler = '0;
		for (int c = 0; c < NCH; c++)
			blink[c] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every tick processed for the directed part; polarity stays at reset (0x1F)
		write_reg(mclbc_pkg::CFG_TICK_DIVIDE, 8'd1);

		//      kind                  ch  on        off       cycles    typed pins   run
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1F, 8'h00); // reset
		add_row(mclbc_pkg::REQ_START, 7,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 8'h9F, 8'h80); // all ones
		add_row(mclbc_pkg::REQ_START, 0,  16'h0000, 16'h0003, 16'h0001, 1, 8'h9F, 8'h80); // zero on
		add_row(REQ_UNUSED,           3,  16'h1234, 16'h5678, 16'h9ABC, 1, 8'h9F, 8'h80); // unused
		add_row(mclbc_pkg::REQ_STOP,  7,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1F, 8'h00); // dark
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1F, 8'h00); // taken
		add_row(mclbc_pkg::REQ_START, 0,  16'h0001, 16'h0001, 16'h0001, 1, 8'h1E, 8'h01);
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1F, 8'h01); // on over
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1F, 8'h00); // cyc end
		add_row(mclbc_pkg::REQ_START, 1,  16'h0002, 16'h0000, 16'h0000, 1, 8'h1D, 8'h02); // steady
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 1, 8'h1D, 8'h02);
		// the rest are checked against the model only
		add_row(mclbc_pkg::REQ_START, 2,  16'h0001, 16'h0002, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_TICK,  5,  16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_STOP,  2,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_START, 2,  16'h0003, 16'h0001, 16'h0002, 0, 8'h00, 8'h00); // clears
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_STOP,  1,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_STOP,  1,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00); // twice
		add_row(mclbc_pkg::REQ_START, 4,  16'h0001, 16'hFFFF, 16'h0000, 0, 8'h00, 8'h00); // long
		add_row(mclbc_pkg::REQ_START, 6,  16'hFFFF, 16'h0001, 16'hFFFF, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);
		add_row(mclbc_pkg::REQ_TICK,  0,  16'h0000, 16'h0000, 16'h0000, 0, 8'h00, 8'h00);

		foreach (table_rows[i])
			put_item(table_rows[i].item, table_rows[i].known, table_rows[i].levels);

		// random traffic: divider and polarity extremes, divider of zero,
		// one phase pausing the sender midway until all results are back
		run_phase(8'd1,   8'h00, 150, -1);
		run_phase(8'd2,   8'hFF, 130, 65);
		run_phase(8'd0,   8'($urandom_range(0, 255)), 100, -1);
		run_phase(8'd255, 8'hA5, 50, -1);
		run_phase(8'd3,   8'($urandom_range(0, 255)), 120, -1);

		// wait out everything still owed, then settle before the verdict
		@(negedge clk);
		req_ch.valid = 1'b0;
		waited = 0;
		while (pending_levels.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_levels.size() != 0) begin
			err_count++;
			$display("%0t: %0d results never arrived", $time, pending_levels.size());
		end

		if (err_count == 0)
			$display("** multi_channel_led_blink_controller_unit: PASSED **");
		else
			$display("** multi_channel_led_blink_controller_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/mclbc_pkg.sv
sv/mclbc_if.sv
sv/multi_channel_led_blink_controller_unit.sv
sv/mclbc_checker.sv
verif/testbench.sv
